// File: rtl/assert_macros.svh
// assertion helpers used by display_mode_table_selector
// expects i_clk and i_rst_n in the scope of the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising clock edge outside reset
`define ASSERT_CLKD(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// checked on every rising clock edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) \
        else $error(msg);

`endif

// File: rtl/dmts_pkg.sv
// shared types, codes and field layout for the display mode table selector
// no dependencies
`default_nettype none

package dmts_pkg;

    localparam int DefTableDepth = 16;

    // field widths
    localparam int ActionW = 2;
    localparam int ResW    = 16;
    localparam int RateW   = 10;
    localparam int IdentW  = 8;
    localparam int SceneW  = 16;
    localparam int StatusW = 3;

    // input tdata layout, lowest bit first
    localparam int InWidthLo  = 0;
    localparam int InHeightLo = InWidthLo + ResW;
    localparam int InRateLo   = InHeightLo + ResW;
    localparam int InIdentLo  = InRateLo + RateW;
    localparam int InSceneLo  = InIdentLo + IdentW;
    localparam int InUsedW    = InSceneLo + SceneW;
    localparam int InDataW    = ((InUsedW + 7) / 8) * 8;

    // output tdata layout, lowest bit first
    localparam int OutUsedW = StatusW + IdentW + RateW;
    localparam int OutDataW = ((OutUsedW + 7) / 8) * 8;

    // actions
    localparam logic [ActionW-1:0] ACT_ADD      = 2'd0;
    localparam logic [ActionW-1:0] ACT_SET_RATE = 2'd1;
    localparam logic [ActionW-1:0] ACT_SET_RES  = 2'd2;
    localparam logic [ActionW-1:0] ACT_GET      = 2'd3;

    // status codes
    localparam logic [StatusW-1:0] ST_OK               = 3'd0;
    localparam logic [StatusW-1:0] ST_RATE_UNSUPPORTED = 3'd1;
    localparam logic [StatusW-1:0] ST_SWITCH_REJECTED  = 3'd2;
    localparam logic [StatusW-1:0] ST_NO_MATCH         = 3'd3;
    localparam logic [StatusW-1:0] ST_MODE_EXISTS      = 3'd4;
    localparam logic [StatusW-1:0] ST_TABLE_FULL       = 3'd5;
    localparam logic [StatusW-1:0] ST_ACTIVE_UNKNOWN   = 3'd6;

    // one table row as stored in the mode memory
    typedef struct packed {
        logic [IdentW-1:0] ident;
        logic [RateW-1:0]  rate;
        logic [ResW-1:0]   height;
        logic [ResW-1:0]   width;
    } t_entry;

    localparam int EntryW = $bits(t_entry);

endpackage

`default_nettype wire

// File: rtl/dmts_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`default_nettype none

module dmts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/display_mode_table_selector.sv
// Display mode table selector. Each word is handled alone, one at a time: the
// mode memory is swept once (add, get) or, for a set that passes its checks,
// twice, one row per cycle with registered read data. The sweep over the
// single-read-port mode memory sets how long a word takes. A finished
// result waits in the output register while the next word is taken in. Writing
// the start mode register reloads the active mode; do so only while idle.
// Depends on dmts_pkg, dmts_ram and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module display_mode_table_selector
    import dmts_pkg::*;
#(
    parameter int TABLE_DEPTH = DefTableDepth
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // start mode register
    input  wire logic                i_cfg_wr_en,
    input  wire logic [IdentW-1:0]   i_cfg_wr_data,
    // request stream
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    // width[15:0], height[31:16], rate[41:32], mode_id[49:42], scene_id[65:50]
    input  wire logic [InDataW-1:0]  s_axis_tdata,
    // action[1:0]
    input  wire logic [ActionW-1:0]  s_axis_tuser,
    // result stream
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    // status[2:0], found_mode[10:3], active_rate[20:11]
    output logic [OutDataW-1:0]      m_axis_tdata
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN1 = 2'd1;
    localparam logic [1:0] S_SCAN2 = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    // control
    logic [1:0]           r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic [CW-1:0]        r_rd_idx, n_rd_idx;
    logic                 r_pend, n_pend;
    logic                 r_hit, n_hit;
    logic                 r_rate_seen, n_rate_seen;
    logic                 r_match, n_match;
    logic [IdentW-1:0]    r_active, n_active;
    logic                 r_m_valid, n_m_valid;

    // payload
    logic [ActionW-1:0]   r_action, n_action;
    logic [ResW-1:0]      r_w, n_w;
    logic [ResW-1:0]      r_h, n_h;
    logic [RateW-1:0]     r_rate, n_rate;
    logic [IdentW-1:0]    r_key, n_key;
    logic                 r_neg, n_neg;
    logic [ResW-1:0]      r_cur_w, n_cur_w;
    logic [ResW-1:0]      r_cur_h, n_cur_h;
    logic [RateW-1:0]     r_cur_rate, n_cur_rate;
    logic [IdentW-1:0]    r_found, n_found;
    logic [StatusW-1:0]   r_status, n_status;
    logic [RateW-1:0]     r_arate, n_arate;
    logic [OutDataW-1:0]  r_m_data, n_m_data;

    logic                 in_fire;
    logic                 rd_en;
    logic                 sweep_end;
    logic                 wr_en;
    t_entry               wr_entry;
    t_entry               rd_entry;
    logic [EntryW-1:0]    rd_bits;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign rd_en         = ((r_state == S_SCAN1) || (r_state == S_SCAN2)) && (r_rd_idx < r_count);
    assign sweep_end     = !rd_en && !r_pend;
    assign rd_entry      = t_entry'(rd_bits);

    assign wr_en = (r_state == S_SCAN1) && sweep_end && (r_action == ACT_ADD)
                   && !r_hit && (r_count < DEPTH_C);
    assign wr_entry = '{ident: r_key, rate: r_rate, height: r_h, width: r_w};

    dmts_ram #(
        .WIDTH (EntryW),
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_mode_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (wr_entry),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rd_idx[AW-1:0]),
        .o_rd_data (rd_bits)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_rd_idx    = r_rd_idx;
        n_pend      = rd_en;
        n_hit       = r_hit;
        n_rate_seen = r_rate_seen;
        n_match     = r_match;
        n_active    = r_active;
        n_m_valid   = r_m_valid;
        n_action    = r_action;
        n_w         = r_w;
        n_h         = r_h;
        n_rate      = r_rate;
        n_key       = r_key;
        n_neg       = r_neg;
        n_cur_w     = r_cur_w;
        n_cur_h     = r_cur_h;
        n_cur_rate  = r_cur_rate;
        n_found     = r_found;
        n_status    = r_status;
        n_arate     = r_arate;
        n_m_data    = r_m_data;

        if (rd_en) begin
            n_rd_idx = r_rd_idx + CW'(1);
        end

        if (m_axis_tvalid && m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_action    = s_axis_tuser;
                    n_w         = s_axis_tdata[InWidthLo +: ResW];
                    n_h         = s_axis_tdata[InHeightLo +: ResW];
                    n_rate      = s_axis_tdata[InRateLo +: RateW];
                    n_neg       = s_axis_tdata[InSceneLo + SceneW - 1];
                    n_key       = (s_axis_tuser == ACT_ADD)
                                  ? s_axis_tdata[InIdentLo +: IdentW] : r_active;
                    n_rd_idx    = '0;
                    n_hit       = 1'b0;
                    n_rate_seen = 1'b0;
                    n_match     = 1'b0;
                    n_found     = '0;
                    n_arate     = '0;
                    n_status    = ST_OK;
                    n_state     = S_SCAN1;
                end
            end
            S_SCAN1: begin
                if (r_pend) begin
                    // first row with the key wins
                    if (!r_hit && (rd_entry.ident == r_key)) begin
                        n_hit      = 1'b1;
                        n_cur_w    = rd_entry.width;
                        n_cur_h    = rd_entry.height;
                        n_cur_rate = rd_entry.rate;
                    end
                    if (rd_entry.rate == r_rate) begin
                        n_rate_seen = 1'b1;
                    end
                end
                if (sweep_end) begin
                    n_state = S_DONE;
                    case (r_action)
                        ACT_ADD: begin
                            if (r_hit) begin
                                n_status = ST_MODE_EXISTS;
                            end else if (r_count >= DEPTH_C) begin
                                n_status = ST_TABLE_FULL;
                            end else begin
                                n_count = r_count + CW'(1);
                            end
                        end
                        ACT_GET: begin
                            if (r_hit) begin
                                n_arate = r_cur_rate;
                            end else begin
                                n_status = ST_ACTIVE_UNKNOWN;
                            end
                        end
                        default: begin
                            if ((r_action == ACT_SET_RATE) && !r_rate_seen) begin
                                n_status = ST_RATE_UNSUPPORTED;
                            end else if (!r_hit) begin
                                n_status = ST_ACTIVE_UNKNOWN;
                            end else if ((r_rate == r_cur_rate) || r_neg) begin
                                n_status = ST_SWITCH_REJECTED;
                            end else begin
                                // set-rate keeps the active resolution
                                if (r_action == ACT_SET_RATE) begin
                                    n_w = r_cur_w;
                                    n_h = r_cur_h;
                                end
                                n_rd_idx = '0;
                                n_state  = S_SCAN2;
                            end
                        end
                    endcase
                end
            end
            S_SCAN2: begin
                if (r_pend && !r_match && (rd_entry.rate == r_rate)
                        && (rd_entry.width == r_w) && (rd_entry.height == r_h)) begin
                    n_match = 1'b1;
                    n_found = rd_entry.ident;
                end
                if (sweep_end) begin
                    if (r_match) begin
                        n_active = r_found;
                    end else begin
                        n_status = ST_NO_MATCH;
                    end
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_axis_tvalid || m_axis_tready) begin
                    n_m_valid = 1'b1;
                    n_m_data  = OutDataW'({r_arate, r_found, r_status});
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_wr_en) begin
            n_active = i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rd_idx    <= '0;
            r_pend      <= 1'b0;
            r_hit       <= 1'b0;
            r_rate_seen <= 1'b0;
            r_match     <= 1'b0;
            r_active    <= '0;
            r_m_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rd_idx    <= n_rd_idx;
            r_pend      <= n_pend;
            r_hit       <= n_hit;
            r_rate_seen <= n_rate_seen;
            r_match     <= n_match;
            r_active    <= n_active;
            r_m_valid   <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action   <= n_action;
        r_w        <= n_w;
        r_h        <= n_h;
        r_rate     <= n_rate;
        r_key      <= n_key;
        r_neg      <= n_neg;
        r_cur_w    <= n_cur_w;
        r_cur_h    <= n_cur_h;
        r_cur_rate <= n_cur_rate;
        r_found    <= n_found;
        r_status   <= n_status;
        r_arate    <= n_arate;
        r_m_data   <= n_m_data;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    `ASSERT_CLKD(a_count_bound, r_count <= DEPTH_C, "table count beyond depth")
    `ASSERT_CLKD(a_read_in_range, rd_en |-> (r_rd_idx < r_count),
        "mode memory read past the filled rows")
    `ASSERT_CLKD(a_count_only_on_add,
        ($past(i_rst_n) && (r_count != $past(r_count)))
            |-> $past(wr_en) && (r_count == $past(r_count) + CW'(1)),
        "table count moved without an add")
    `ASSERT_CLKD(a_result_from_done,
        ($past(i_rst_n) && $rose(m_axis_tvalid)) |-> $past(r_state == S_DONE),
        "result word raised outside the done step")

endmodule

`default_nettype wire

// File: tb/tb_display_mode_table_selector.sv
// testbench for display_mode_table_selector: a directed table, then phases of random words
// each checked against a behavioral predictor of the mode table, with random stalls on both streams
// depends on dmts_pkg and the display_mode_table_selector rtl
`default_nettype none

module tb_display_mode_table_selector;
    timeunit 1ns;
    timeprecision 1ps;

    import dmts_pkg::*;

    localparam int ModeDepth   = DefTableDepth;
    localparam int RandomWords = 1500;
    localparam int StallLimit  = 2000;

    typedef struct packed {
        logic [ActionW-1:0] action;
        logic [ResW-1:0]    width;
        logic [ResW-1:0]    height;
        logic [RateW-1:0]   rate;
        logic [IdentW-1:0]  ident;
        logic [SceneW-1:0]  scene;
    } t_mode_req;

    typedef struct packed {
        logic [StatusW-1:0] status;
        logic [IdentW-1:0]  found;
        logic [RateW-1:0]   arate;
    } t_mode_result;

    typedef struct packed {
        t_mode_req    req;
        logic         typed;
        t_mode_result typed_res;
    } t_table_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_wr_en;
    logic [IdentW-1:0]   i_cfg_wr_data;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [InDataW-1:0]  s_axis_tdata;
    logic [ActionW-1:0]  s_axis_tuser;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [OutDataW-1:0] m_axis_tdata;

    // predictor copy of the mode table
    logic [ResW-1:0]   mode_w  [ModeDepth];
    logic [ResW-1:0]   mode_h  [ModeDepth];
    logic [RateW-1:0]  mode_hz [ModeDepth];
    logic [IdentW-1:0] mode_id [ModeDepth];
    int                mode_count;
    logic [IdentW-1:0] active_id;

    t_mode_result awaited_replies[$];
    t_table_row   directed_rows[$];
    int           error_count;
    int           burst_left;
    bit           steady_sender;
    int           idle_cycles;
    int           rx_tick;
    int           rx_mode;

    display_mode_table_selector #(
        .TABLE_DEPTH(ModeDepth)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_mode_result apply_mode_request(t_mode_req r);
        t_mode_result res;
        int act;
        int hit;
        int i;
        bit hz_seen;
        logic [ResW-1:0] w;
        logic [ResW-1:0] h;
        res = '0;
        act = -1;
        hit = -1;
        hz_seen = 1'b0;
        w = r.width;
        h = r.height;
        for (i = 0; i < mode_count; i++) begin
            if (act < 0 && mode_id[i] == active_id) act = i;
            if (mode_hz[i] == r.rate) hz_seen = 1'b1;
        end
        case (r.action)
            ACT_ADD: begin
                for (i = 0; i < mode_count; i++) begin
                    if (hit < 0 && mode_id[i] == r.ident) hit = i;
                end
                // duplicate id wins over a full table
                if (hit >= 0) begin
                    res.status = ST_MODE_EXISTS;
                end else if (mode_count >= ModeDepth) begin
                    res.status = ST_TABLE_FULL;
                end else begin
                    mode_w[mode_count]  = r.width;
                    mode_h[mode_count]  = r.height;
                    mode_hz[mode_count] = r.rate;
                    mode_id[mode_count] = r.ident;
                    mode_count++;
                end
            end
            ACT_GET: begin
                if (act < 0) res.status = ST_ACTIVE_UNKNOWN;
                else res.arate = mode_hz[act];
            end
            default: begin
                if (r.action == ACT_SET_RATE && !hz_seen) begin
                    res.status = ST_RATE_UNSUPPORTED;
                end else if (act < 0) begin
                    res.status = ST_ACTIVE_UNKNOWN;
                end else if (r.rate == mode_hz[act] || r.scene[SceneW-1]) begin
                    res.status = ST_SWITCH_REJECTED;
                end else begin
                    // set rate keeps the active resolution
                    if (r.action == ACT_SET_RATE) begin
                        w = mode_w[act];
                        h = mode_h[act];
                    end
                    for (i = 0; i < mode_count; i++) begin
                        if (hit < 0 && mode_hz[i] == r.rate && mode_w[i] == w && mode_h[i] == h)
                            hit = i;
                    end
                    if (hit < 0) begin
                        res.status = ST_NO_MATCH;
                    end else begin
                        res.found = mode_id[hit];
                        active_id = mode_id[hit];
                    end
                end
            end
        endcase
        return res;
    endfunction

    function automatic void add_row(logic [ActionW-1:0] act, int w, int h, int hz, int id,
                                    int scene, bit typed, logic [StatusW-1:0] st, int fm, int ar);
        t_table_row row;
        row.req.action     = act;
        row.req.width      = ResW'(w);
        row.req.height     = ResW'(h);
        row.req.rate       = RateW'(hz);
        row.req.ident      = IdentW'(id);
        row.req.scene      = SceneW'(scene);
        row.typed          = typed;
        row.typed_res.status = st;
        row.typed_res.found  = IdentW'(fm);
        row.typed_res.arate  = RateW'(ar);
        directed_rows.push_back(row);
    endfunction

    // mostly requests built from table contents so sets get past the early checks
    function automatic t_mode_req random_request();
        t_mode_req r;
        int pick;
        int j;
        int k;
        r.action = ActionW'($urandom);
        r.width  = ResW'($urandom);
        r.height = ResW'($urandom);
        r.rate   = RateW'($urandom);
        r.ident  = IdentW'($urandom);
        r.scene  = SceneW'($urandom);
        pick = $urandom_range(0, 99);
        j = $urandom_range(0, mode_count - 1);
        k = $urandom_range(0, mode_count - 1);
        if (pick < 12) begin
            r.action = ACT_ADD;
            if ($urandom_range(0, 1) == 0) r.ident = mode_id[j];
        end else if (pick < 45) begin
            r.action = ACT_SET_RATE;
            if ($urandom_range(0, 4) != 0) r.rate = mode_hz[j];
        end else if (pick < 80) begin
            r.action = ACT_SET_RES;
            case ($urandom_range(0, 3))
                0, 1: begin
                    r.width  = mode_w[j];
                    r.height = mode_h[j];
                    r.rate   = mode_hz[j];
                end
                2: begin
                    r.width  = mode_w[j];
                    r.height = mode_h[j];
                    r.rate   = mode_hz[k];
                end
                default: ;
            endcase
        end else if (pick < 95) begin
            r.action = ACT_GET;
        end
        if ((r.action == ACT_SET_RATE || r.action == ACT_SET_RES) && $urandom_range(0, 3) != 0)
            r.scene[SceneW-1] = 1'b0;
        return r;
    endfunction

    task automatic send_request(input t_mode_req r, input bit typed, input t_mode_result typed_res);
        t_mode_result res;
        logic [InDataW-1:0] d;
        int gap;
        d = '0;
        d[InWidthLo +: ResW]    = r.width;
        d[InHeightLo +: ResW]   = r.height;
        d[InRateLo +: RateW]    = r.rate;
        d[InIdentLo +: IdentW]  = r.ident;
        d[InSceneLo +: SceneW]  = r.scene;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tuser  <= r.action;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        res = apply_mode_request(r);
        awaited_replies.push_back(typed ? typed_res : res);
        if (burst_left > 0 || steady_sender) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 45) : $urandom_range(1, 6);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // drop valid and wait until every reply is back
    task automatic settle_block();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (awaited_replies.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_start_mode(input logic [IdentW-1:0] value);
        settle_block();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        active_id = value;
    endtask

    // result side: ready follows one of four patterns, redrawn at random from time to time
    always @(posedge i_clk) begin
        rx_tick <= rx_tick + 1;
        if (rx_tick % 300 == 0) rx_mode <= $urandom_range(0, 3);
        case (rx_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom);
            2: m_axis_tready <= (rx_tick % 16) < 8;
            default: m_axis_tready <= (rx_tick % 5) == 0;
        endcase
    end

    always @(posedge i_clk) begin
        t_mode_result got;
        t_mode_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status = m_axis_tdata[0 +: StatusW];
            got.found  = m_axis_tdata[StatusW +: IdentW];
            got.arate  = m_axis_tdata[StatusW + IdentW +: RateW];
            if (awaited_replies.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result word status %0d found %0d rate %0d",
                         $time, got.status, got.found, got.arate);
            end else begin
                want = awaited_replies.pop_front();
                if (got.status !== want.status) begin
                    error_count++;
                    $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
                end
                if (got.found !== want.found) begin
                    error_count++;
                    $display("%0t: found_mode expected %0d actual %0d", $time, want.found, got.found);
                end
                if (got.arate !== want.arate) begin
                    error_count++;
                    $display("%0t: active_rate expected %0d actual %0d", $time, want.arate, got.arate);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= StallLimit) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        int sent;
        int n;
        logic [IdentW-1:0] start_id;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        mode_count    = 0;
        active_id     = '0;
        error_count   = 0;
        burst_left    = 0;
        steady_sender = 1'b0;
        idle_cycles   = 0;
        rx_tick       = 1;
        rx_mode       = 0;

        // empty table, extremes, then fill up and overflow
        add_row(ACT_GET,      0, 0, 0, 0, 0, 1, ST_ACTIVE_UNKNOWN, 0, 0);
        add_row(ACT_SET_RATE, 1920, 1080, 60, 0, 0, 1, ST_RATE_UNSUPPORTED, 0, 0);
        add_row(ACT_SET_RES,  0, 0, 60, 0, 0, 1, ST_ACTIVE_UNKNOWN, 0, 0);
        add_row(ACT_ADD,      0, 0, 0, 0, 0, 1, ST_OK, 0, 0);
        add_row(ACT_ADD,      5, 5, 5, 0, 0, 1, ST_MODE_EXISTS, 0, 0);
        add_row(ACT_ADD,      65535, 65535, 1023, 255, -1, 1, ST_OK, 0, 0);
        add_row(ACT_SET_RATE, 0, 0, 1023, 0, 0, 0, ST_OK, 0, 0);
        add_row(ACT_SET_RATE, 0, 0, 0, 0, 100, 0, ST_OK, 0, 0);
        add_row(ACT_SET_RES,  65535, 65535, 1023, 0, -32768, 0, ST_OK, 0, 0);
        add_row(ACT_SET_RES,  65535, 65535, 1023, 0, 32767, 0, ST_OK, 0, 0);
        add_row(ACT_GET,      0, 0, 0, 0, 0, 0, ST_OK, 0, 0);
        add_row(ACT_ADD, 1920, 1080, 60,  1, 0, 1, ST_OK, 0, 0);
        add_row(ACT_ADD, 1920, 1080, 120, 2, 0, 1, ST_OK, 0, 0);
        add_row(ACT_ADD, 1920, 1080, 90,  3, 0, 1, ST_OK, 0, 0);
        add_row(ACT_ADD, 1280, 720,  60,  4, 0, 1, ST_OK, 0, 0);
        add_row(ACT_ADD, 1280, 720,  30,  5, 0, 1, ST_OK, 0, 0);
        add_row(ACT_ADD, 3840, 2160, 60,  6, 0, 1, ST_OK, 0, 0);
        add_row(ACT_ADD, 3840, 2160, 144, 7, 0, 1, ST_OK, 0, 0);
        add_row(ACT_ADD, 1920, 1080, 144, 8, 0, 1, ST_OK, 0, 0);
        add_row(ACT_ADD, 1280, 720,  120, 9, 0, 1, ST_OK, 0, 0);
        add_row(ACT_ADD, 3840, 2160, 30,  10, 0, 1, ST_OK, 0, 0);
        add_row(ACT_ADD, 0, 0, 60, 11, 0, 1, ST_OK, 0, 0);
        add_row(ACT_ADD, 65535, 65535, 60, 12, 0, 1, ST_OK, 0, 0);
        // same resolution and rate as id 1: the earlier entry must win
        add_row(ACT_ADD, 1920, 1080, 60,  13, 0, 1, ST_OK, 0, 0);
        add_row(ACT_ADD, 3840, 2160, 120, 14, 0, 1, ST_OK, 0, 0);
        add_row(ACT_ADD, 800, 600, 75, 100, 0, 1, ST_TABLE_FULL, 0, 0);
        add_row(ACT_ADD, 800, 600, 75, 7, 0, 1, ST_MODE_EXISTS, 0, 0);
        add_row(ACT_SET_RATE, 0, 0, 60, 0, 1, 0, ST_OK, 0, 0);
        add_row(ACT_GET, 0, 0, 0, 0, 0, 0, ST_OK, 0, 0);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_start_mode('0);
        foreach (directed_rows[r])
            send_request(directed_rows[r].req, directed_rows[r].typed, directed_rows[r].typed_res);

        sent = 0;
        while (sent < RandomWords) begin
            case ($urandom_range(0, 5))
                0: start_id = '0;
                1: start_id = '1;
                5: start_id = IdentW'($urandom);
                default: start_id = mode_id[$urandom_range(0, mode_count - 1)];
            endcase
            write_start_mode(start_id);
            steady_sender = ($urandom_range(0, 3) == 0);
            n = $urandom_range(40, 160);
            repeat (n) begin
                send_request(random_request(), 1'b0, '0);
                sent++;
            end
        end

        settle_block();
        repeat (48) @(posedge i_clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
